### hw/rtl/rpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_pkg: shared definitions for the RMS power meter
// Field widths, register indexes, word codes, reset values and the widths
// of the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package rpm_pkg;

  // Input word fields.
  localparam int FUNC_W = 2;
  localparam int ADC_W  = 10;

  // Default resolution of the converter codes that are squared.
  localparam int SAMPLE_BITS_DEF = 10;

  // Word codes of the func field; the fourth code is ignored.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES_PER_TICK = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_PHASE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_GAIN     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_GAIN     = 2'd3;

  localparam int SPT_W  = 3;
  localparam int TPP_W  = 5;
  localparam int GAIN_W = 16;

  localparam logic [SPT_W-1:0]  SPT_RST   = 3'd3;
  localparam logic [TPP_W-1:0]  TPP_RST   = 5'd21;
  localparam logic [GAIN_W-1:0] IGAIN_RST = 16'd17067;
  localparam logic [GAIN_W-1:0] VGAIN_RST = 16'd18176;

  // Result word fields.
  localparam int RMS_W   = 14;
  localparam int POWER_W = 20;

  // Accumulation state.
  localparam int SUM_W = 28;
  localparam int CNT_W = 8;

  // Mean square is the sum scaled by 2^12 before the division (Q.12).
  localparam int FRAC_SHIFT = 12;
  localparam int DIV_W      = SUM_W + FRAC_SHIFT;
  localparam int ROOT_W     = DIV_W / 2;

  // Shared shift-and-add multiplier.
  localparam int MUL_A_W = ROOT_W;
  localparam int MUL_B_W = GAIN_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Output scaling: rms code in Q.6 times gain in Q.20 gives Q.26, kept in Q.8.
  localparam int SCALE_SHIFT = 18;
  localparam int POWER_SHIFT = 8;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_ROOT,
    ST_SCALE,
    ST_POWER,
    ST_DELIVER
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/rpm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_if: word channels of the RMS power meter
// Valid/ready channels for the input words and for the result words.
// ----------------------------------------------------------------------------

// Input channel: timer ticks, converter samples and start words.
interface rpm_in_if;
  logic                       valid;
  logic                       ready;
  logic [rpm_pkg::FUNC_W-1:0] func;
  logic [rpm_pkg::ADC_W-1:0]  adc_sample;

  modport source (output valid, output func, output adc_sample, input ready);
  modport sink   (input valid, input func, input adc_sample, output ready);
endinterface

// Result channel: one word per finished measurement.
interface rpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpm_pkg::RMS_W-1:0]   rms_current;
  logic [rpm_pkg::RMS_W-1:0]   rms_voltage;
  logic [rpm_pkg::POWER_W-1:0] avg_power;

  modport source (output valid, output rms_current, output rms_voltage,
                  output avg_power, input ready);
  modport sink   (input valid, input rms_current, input rms_voltage,
                  input avg_power, output ready);
endinterface

`default_nettype wire

### hw/rtl/rpm_serial_mult.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_serial_mult: shift-and-add multiplier
// Retires one bit of the multiplier per cycle, least significant first, so
// only one narrow adder sits between registers. Done pulses once the
// product register holds the full result.
// ----------------------------------------------------------------------------
module rpm_serial_mult (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rpm_pkg::MUL_A_W-1:0] a,
  input  wire logic [rpm_pkg::MUL_B_W-1:0] b,
  output logic                             done,
  output logic [rpm_pkg::MUL_P_W-1:0]      prod
);

  localparam int AW = rpm_pkg::MUL_A_W;
  localparam int BW = rpm_pkg::MUL_B_W;
  localparam int PW = rpm_pkg::MUL_P_W;
  localparam int CW = $clog2(BW);

  logic [AW-1:0] a_r;
  logic [PW-1:0] p_r, p_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          last;
  logic [AW:0]   sum_w;

  // The upper half accumulates; the lower half still holds unused multiplier bits.
  assign last  = (cnt_r == CW'(BW - 1));
  assign sum_w = {1'b0, p_r[PW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW + 1){1'b0}});

  always_comb begin
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && last;
    if (start) begin
      p_nxt    = {{AW{1'b0}}, b};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum_w, p_r[BW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Sequencing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

`default_nettype wire

### hw/rtl/rpm_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_serial_div: restoring divider
// Produces one quotient bit per cycle, most significant first, using a
// compare and subtract one bit wider than the divisor.
// ----------------------------------------------------------------------------
module rpm_serial_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rpm_pkg::DIV_W-1:0] dividend,
  input  wire logic [rpm_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [rpm_pkg::DIV_W-1:0]      quotient
);

  localparam int DW = rpm_pkg::DIV_W;
  localparam int VW = rpm_pkg::CNT_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          last;
  logic [VW:0]   rem_sh, diff;
  logic          ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign last   = (cnt_r == CW'(DW - 1));
  assign rem_sh = {rem_r, q_r[DW-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = (rem_sh >= {1'b0, d_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && last;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Sequencing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Quotient shift register, partial remainder and divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

### hw/rtl/rpm_serial_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_serial_sqrt: digit-by-digit integer square root
// Consumes two radicand bits per cycle and settles one root bit, giving the
// floor of the square root.
// ----------------------------------------------------------------------------
module rpm_serial_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rpm_pkg::DIV_W-1:0]  radicand,
  output logic                            done,
  output logic [rpm_pkg::ROOT_W-1:0]      root
);

  localparam int RW = rpm_pkg::DIV_W;
  localparam int TW = rpm_pkg::ROOT_W;
  localparam int CW = $clog2(TW);

  logic [RW-1:0]   x_r, x_nxt;
  logic [TW-1:0]   root_r, root_nxt;
  logic [TW+1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            last;
  logic [TW+3:0]   rem_sh, trial, diff;
  logic            ge;

  // Bring down the next pair of bits and test the trial value 4*root+1.
  assign last   = (cnt_r == CW'(TW - 1));
  assign rem_sh = {rem_r, x_r[RW-1:RW-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_comb begin
    x_nxt    = x_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && last;
    if (start) begin
      x_nxt    = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[RW-3:0], 2'b00};
      root_nxt = {root_r[TW-2:0], ge};
      rem_nxt  = ge ? diff[TW+1:0] : rem_sh[TW+1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Sequencing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Radicand shift register, partial root and remainder.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

### hw/rtl/rms_power_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rms_power_meter: RMS current, RMS voltage and average power meter
// Accumulates squared converter codes over a current phase and a voltage
// phase and reports both RMS values and their product.
// ----------------------------------------------------------------------------
// Usage
//   in_chan carries words with func (tick, sample, start) and adc_sample.
//   Each tick opens a window of samples_per_tick samples; the tick after
//   ticks_per_phase ticks evaluates the phase. After the voltage phase one
//   word (rms_current, rms_voltage, avg_power) leaves on out_chan and the
//   meter ignores ticks and samples until a start word.
//   cfg_we/cfg_addr/cfg_wdata write the four registers; write them while idle.
// Sequencing
//   Ticks that open a window and ignored words leave the sequencer idle. A
//   sample is squared by the 16-step serial multiplier.
//   An evaluating tick runs 40 divider steps, 20 root steps and 16
//   multiplier steps for the gain. In the voltage phase 16 more steps form
//   the power, and the word is then loaded once the output register is free.
//   No further word is taken until the sequencer is idle again. With no
//   samples the divider and root are skipped.
//   in_chan.ready is high only while the sequencer is idle.
// Reset and stalls
//   Reset restores the register defaults and clears the measurement state apart from volts_r and power_r.
//   The result waits in an output register; further words are still taken,
//   and only a later result waits until the register has been emptied.
// ----------------------------------------------------------------------------
module rms_power_meter #(
  parameter int SAMPLE_BITS = rpm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rpm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rpm_in_if.sink                              in_chan,
  rpm_out_if.source                           out_chan
);

  localparam int CODE_W = (SAMPLE_BITS < rpm_pkg::ADC_W) ? SAMPLE_BITS : rpm_pkg::ADC_W;
  localparam int SQ_W   = 2 * CODE_W;
  localparam int AW     = rpm_pkg::MUL_A_W;
  localparam int BW     = rpm_pkg::MUL_B_W;
  localparam int PW     = rpm_pkg::MUL_P_W;
  localparam int SUM_W  = rpm_pkg::SUM_W;
  localparam int CNT_W  = rpm_pkg::CNT_W;
  localparam int RMS_W  = rpm_pkg::RMS_W;
  localparam int PWR_W  = rpm_pkg::POWER_W;
  localparam int SCL_W  = PW - rpm_pkg::SCALE_SHIFT;
  localparam int PWS_W  = PW - rpm_pkg::POWER_SHIFT;

  // Configuration registers.
  logic [rpm_pkg::SPT_W-1:0]  spt_r;
  logic [rpm_pkg::TPP_W-1:0]  tpp_r;
  logic [rpm_pkg::GAIN_W-1:0] igain_r;
  logic [rpm_pkg::GAIN_W-1:0] vgain_r;

  // Measurement state.
  rpm_pkg::state_t            state_r, state_nxt;
  logic                       phase_r, phase_nxt;
  logic                       eval_volt_r, eval_volt_nxt;
  logic [rpm_pkg::TPP_W-1:0]  tick_count_r, tick_count_nxt;
  logic                       window_open_r, window_open_nxt;
  logic [rpm_pkg::SPT_W-1:0]  window_samples_r, window_samples_nxt;
  logic [CNT_W-1:0]           sample_count_r, sample_count_nxt;
  logic [SUM_W-1:0]           square_sum_r, square_sum_nxt;
  logic [RMS_W-1:0]           held_current_r, held_current_nxt;
  logic                       finished_r, finished_nxt;
  logic [RMS_W-1:0]           volts_r, volts_nxt;
  logic [PWR_W-1:0]           power_r, power_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [RMS_W-1:0]           out_current_r;
  logic [RMS_W-1:0]           out_voltage_r;
  logic [PWR_W-1:0]           out_power_r;

  // Handshake decode.
  logic                       in_ready;
  logic                       accept;
  logic                       active;
  logic                       sample_go;
  logic                       tick_go;
  logic                       open_go;
  logic                       eval_go;
  logic                       start_go;
  logic                       out_free;
  logic [CODE_W-1:0]          code;

  // Arithmetic unit connections.
  logic                       mult_start, mult_done;
  logic [AW-1:0]              mult_a;
  logic [BW-1:0]              mult_b;
  logic [PW-1:0]              mult_prod;
  logic                       div_start, div_done;
  logic [rpm_pkg::DIV_W-1:0]  div_quot;
  logic                       sqrt_start, sqrt_done;
  logic [rpm_pkg::ROOT_W-1:0] sqrt_root;

  // Derived arithmetic values.
  logic [SQ_W-1:0]            square;
  logic [SUM_W:0]             sum_ext;
  logic [SUM_W-1:0]           sum_sat;
  logic [SCL_W-1:0]           scaled;
  logic [RMS_W-1:0]           rms_sat;
  logic [PWS_W-1:0]           power_full;
  logic [PWR_W-1:0]           power_sat;
  logic [rpm_pkg::GAIN_W-1:0] gain_now;
  logic [rpm_pkg::GAIN_W-1:0] gain_eval;
  logic [rpm_pkg::SPT_W-1:0]  window_inc;

  // Arithmetic units.
  rpm_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mult_start),
    .a     (mult_a),
    .b     (mult_b),
    .done  (mult_done),
    .prod  (mult_prod)
  );

  rpm_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({square_sum_r, {rpm_pkg::FRAC_SHIFT{1'b0}}}),
    .divisor  (sample_count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  rpm_serial_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_quot),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Word decode: only the idle sequencer takes words.
  assign in_ready  = (state_r == rpm_pkg::ST_IDLE);
  assign accept    = in_chan.valid && in_ready;
  assign active    = !finished_r;
  assign code      = in_chan.adc_sample[CODE_W-1:0];
  assign start_go  = accept && (in_chan.func == rpm_pkg::FUNC_START);
  assign sample_go = accept && (in_chan.func == rpm_pkg::FUNC_SAMPLE) && active
                     && window_open_r;
  assign tick_go   = accept && (in_chan.func == rpm_pkg::FUNC_TICK) && active;
  assign open_go   = tick_go && (tick_count_r < tpp_r);
  assign eval_go   = tick_go && !(tick_count_r < tpp_r);
  assign out_free  = !out_valid_r || out_chan.ready;

  // Gain of the phase being accepted, and of the phase being evaluated.
  assign gain_now  = phase_r ? vgain_r : igain_r;
  assign gain_eval = eval_volt_r ? vgain_r : igain_r;

  // Saturating accumulation of the square.
  assign square  = mult_prod[SQ_W-1:0];
  assign sum_ext = {1'b0, square_sum_r} + (SUM_W + 1)'(square);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  // Gain scaling to Q.8, saturated to the field width.
  assign scaled  = mult_prod[PW-1:rpm_pkg::SCALE_SHIFT];
  assign rms_sat = (|scaled[SCL_W-1:RMS_W]) ? {RMS_W{1'b1}} : scaled[RMS_W-1:0];

  // Power in Q.8, saturated to the field width.
  assign power_full = mult_prod[PW-1:rpm_pkg::POWER_SHIFT];
  assign power_sat  = (|power_full[PWS_W-1:PWR_W]) ? {PWR_W{1'b1}}
                                                   : power_full[PWR_W-1:0];

  assign window_inc = window_samples_r + 1'b1;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpm_pkg::ST_IDLE: begin
        if (sample_go) begin
          state_nxt = rpm_pkg::ST_SQUARE;
        end else if (eval_go) begin
          state_nxt = (sample_count_r == '0) ? rpm_pkg::ST_SCALE : rpm_pkg::ST_DIVIDE;
        end
      end
      rpm_pkg::ST_SQUARE: begin
        if (mult_done) begin
          state_nxt = rpm_pkg::ST_IDLE;
        end
      end
      rpm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = rpm_pkg::ST_ROOT;
        end
      end
      rpm_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = rpm_pkg::ST_SCALE;
        end
      end
      rpm_pkg::ST_SCALE: begin
        if (mult_done) begin
          state_nxt = eval_volt_r ? rpm_pkg::ST_POWER : rpm_pkg::ST_IDLE;
        end
      end
      rpm_pkg::ST_POWER: begin
        if (mult_done) begin
          state_nxt = rpm_pkg::ST_DELIVER;
        end
      end
      rpm_pkg::ST_DELIVER: begin
        if (out_free) begin
          state_nxt = rpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts and multiplier operands.
  always_comb begin
    mult_start = 1'b0;
    mult_a     = '0;
    mult_b     = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_r) inside
      rpm_pkg::ST_IDLE: begin
        if (sample_go) begin
          mult_start = 1'b1;
          mult_a     = AW'(code);
          mult_b     = BW'(code);
        end else if (eval_go) begin
          if (sample_count_r == '0) begin
            // No samples: the rms is zero, so only the scaling runs.
            mult_start = 1'b1;
            mult_b     = gain_now;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      rpm_pkg::ST_DIVIDE: begin
        sqrt_start = div_done;
      end
      rpm_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          mult_start = 1'b1;
          mult_a     = sqrt_root;
          mult_b     = gain_eval;
        end
      end
      rpm_pkg::ST_SCALE: begin
        if (mult_done && eval_volt_r) begin
          mult_start = 1'b1;
          mult_a     = AW'(held_current_r);
          mult_b     = BW'(rms_sat);
        end
      end
      rpm_pkg::ST_SQUARE, rpm_pkg::ST_POWER, rpm_pkg::ST_DELIVER: begin
        mult_start = 1'b0;
      end
      default: mult_start = 1'b0;
    endcase
  end

  // Measurement state updates.
  always_comb begin
    phase_nxt          = phase_r;
    eval_volt_nxt      = eval_volt_r;
    tick_count_nxt     = tick_count_r;
    window_open_nxt    = window_open_r;
    window_samples_nxt = window_samples_r;
    sample_count_nxt   = sample_count_r;
    square_sum_nxt     = square_sum_r;
    held_current_nxt   = held_current_r;
    finished_nxt       = finished_r;
    volts_nxt          = volts_r;
    power_nxt          = power_r;

    if (start_go) begin
      phase_nxt          = 1'b0;
      tick_count_nxt     = '0;
      window_open_nxt    = 1'b0;
      window_samples_nxt = '0;
      sample_count_nxt   = '0;
      square_sum_nxt     = '0;
      held_current_nxt   = '0;
      finished_nxt       = 1'b0;
    end else if (open_go) begin
      window_open_nxt    = 1'b1;
      window_samples_nxt = '0;
      tick_count_nxt     = tick_count_r + 1'b1;
    end else if (sample_go) begin
      if (sample_count_r != {CNT_W{1'b1}}) begin
        sample_count_nxt = sample_count_r + 1'b1;
      end
      // The window counter wraps, so a zero window length closes after eight.
      if (window_inc == spt_r) begin
        window_open_nxt    = 1'b0;
        window_samples_nxt = '0;
      end else begin
        window_samples_nxt = window_inc;
      end
    end else if (eval_go) begin
      eval_volt_nxt      = phase_r;
      phase_nxt          = !phase_r;
      tick_count_nxt     = '0;
      window_open_nxt    = 1'b0;
      window_samples_nxt = '0;
      sample_count_nxt   = '0;
      square_sum_nxt     = '0;
    end

    // Results coming back from the multiplier.
    if (state_r == rpm_pkg::ST_SQUARE && mult_done) begin
      square_sum_nxt = sum_sat;
    end
    if (state_r == rpm_pkg::ST_SCALE && mult_done) begin
      if (eval_volt_r) begin
        volts_nxt = rms_sat;
      end else begin
        held_current_nxt = rms_sat;
      end
    end
    if (state_r == rpm_pkg::ST_POWER && mult_done) begin
      power_nxt = power_sat;
    end
    if (state_r == rpm_pkg::ST_DELIVER && out_free) begin
      finished_nxt = 1'b1;
    end
  end

  // Output register: loaded on delivery, emptied when the word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == rpm_pkg::ST_DELIVER && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= rpm_pkg::SPT_RST;
      tpp_r   <= rpm_pkg::TPP_RST;
      igain_r <= rpm_pkg::IGAIN_RST;
      vgain_r <= rpm_pkg::VGAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rpm_pkg::REG_SAMPLES_PER_TICK: spt_r   <= cfg_wdata[rpm_pkg::SPT_W-1:0];
        rpm_pkg::REG_TICKS_PER_PHASE:  tpp_r   <= cfg_wdata[rpm_pkg::TPP_W-1:0];
        rpm_pkg::REG_CURRENT_GAIN:     igain_r <= cfg_wdata[rpm_pkg::GAIN_W-1:0];
        rpm_pkg::REG_VOLTAGE_GAIN:     vgain_r <= cfg_wdata[rpm_pkg::GAIN_W-1:0];
        default:                       spt_r   <= spt_r;
      endcase
    end
  end

  // Control and measurement state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= rpm_pkg::ST_IDLE;
      phase_r          <= 1'b0;
      eval_volt_r      <= 1'b0;
      tick_count_r     <= '0;
      window_open_r    <= 1'b0;
      window_samples_r <= '0;
      sample_count_r   <= '0;
      square_sum_r     <= '0;
      held_current_r   <= '0;
      finished_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      phase_r          <= phase_nxt;
      eval_volt_r      <= eval_volt_nxt;
      tick_count_r     <= tick_count_nxt;
      window_open_r    <= window_open_nxt;
      window_samples_r <= window_samples_nxt;
      sample_count_r   <= sample_count_nxt;
      square_sum_r     <= square_sum_nxt;
      held_current_r   <= held_current_nxt;
      finished_r       <= finished_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Intermediate results and output payload.
  always_ff @(posedge clk) begin
    volts_r <= volts_nxt;
    power_r <= power_nxt;
    if (state_r == rpm_pkg::ST_DELIVER && out_free) begin
      out_current_r <= held_current_r;
      out_voltage_r <= volts_r;
      out_power_r   <= power_r;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.rms_current = out_current_r;
  assign out_chan.rms_voltage = out_voltage_r;
  assign out_chan.avg_power   = out_power_r;

  // A delivery always leaves a word waiting in the output register.
  a_deliver_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpm_pkg::ST_DELIVER && out_free) |=> out_valid_r)
    else $error("delivery did not load the output register");

  // The arithmetic units never finish in the same cycle.
  a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mult_done, div_done, sqrt_done}))
    else $error("more than one arithmetic unit finished at once");

  // A closed window holds no partial sample count.
  a_closed_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !window_open_r |-> (window_samples_r == '0))
    else $error("window sample count left over after the window closed");

  // No samples counted means nothing accumulated.
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_count_r == '0) |-> (square_sum_r == '0))
    else $error("square sum without counted samples");

  // A finished measurement leaves the sequencer idle until the next start.
  a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (state_r == rpm_pkg::ST_IDLE))
    else $error("sequencer busy after the measurement finished");

endmodule

`default_nettype wire
